// ----- sv/sha256_pkg.sv -----
// sha256_pkg: shared types, constants and the rotate function for the sha-256 hasher
// no dependencies
`timescale 1ns / 1ps
package sha256_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       last_byte;
  } sha_in_t;

  typedef struct packed {
    logic [63:0] digest_word_a;
    logic [63:0] digest_word_b;
    logic [63:0] digest_word_c;
    logic [63:0] digest_word_d;
  } sha_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_OUT
  } sha_state_t;

  // command from the controller to the compression engine
  typedef struct packed {
    logic start;
    logic init_hash;
  } sha_cmd_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [255:0] SHA_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- sv/sha256_stream_hasher_core.sv -----
// sha256_stream_hasher_core: streaming sha-256 hasher top level
// depends on sha256_pkg, sha256_buf, sha256_eng
// A byte word is taken and written to the 64-byte buffer memory. When the
// buffer fills, the block streams out of the memory into the compression
// engine at one byte a cycle, four bytes per schedule word. The engine runs
// one round per cycle while its message word is ready. The first 16 rounds
// follow the byte stream; after the last byte of a block is taken come load,
// the 64 byte reads through the registered buffer read and the word handoff,
// 48 free-running rounds and close. Bytes are taken at one per cycle while
// the input is not stalled. A word with last_byte set pads the message into
// one or two final blocks. The digest is then presented as four 64-bit
// big-endian words on out_, and the hash returns to the initial value
// afterwards. The input is stalled while a block is compressed or a digest
// is formed. A finished digest waits in its own output register, so the
// next message can be taken while it sits there. A new digest waits until
// that register is free.
`timescale 1ns / 1ps
module sha256_stream_hasher_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sha256_pkg::sha_in_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sha256_pkg::sha_out_t out_data
);
  import sha256_pkg::*;

  sha_state_t   state_r, state_nxt;
  logic [5:0]   fill_r, fill_nxt;
  logic [63:0]  len_r, len_nxt;
  logic [6:0]   pos_r, pos_nxt;      // byte position of the block being fed
  logic         two_r, two_nxt;      // padding needs two blocks
  logic         blk2_r, blk2_nxt;    // feeding the second padding block
  logic         pad_r, pad_nxt;      // current block is a padding block
  logic [5:0]   rem_r, rem_nxt;      // bytes of message in the tail
  logic [31:0]  word_r, word_nxt;
  logic         out_valid_r, out_valid_nxt;
  sha_out_t     out_r;
  logic         first_r, first_nxt;  // next block starts from the iv

  logic         bw_en;
  logic [5:0]   bw_addr, br_addr;
  logic [7:0]   bw_data, br_data;
  logic         rd_pend_r, rd_pend_nxt;
  logic [6:0]   rd_pos_r;
  sha_cmd_t     cmd;
  logic         eng_busy, word_valid;
  logic [255:0] hash;
  logic         accept;
  logic [7:0]   pbyte;
  logic [6:0]   gpos;

  sha256_buf u_buf (
    .clk(clk), .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(bw_data),
    .rd_addr(br_addr), .rd_data(br_data)
  );

  sha256_eng u_eng (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .word_valid(word_valid),
    .word_in(word_nxt), .busy(eng_busy), .hash(hash)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign bw_en     = accept && in_data.byte_present;
  assign bw_addr   = fill_r;
  assign bw_data   = in_data.msg_byte;
  assign br_addr   = pos_r[5:0];

  // byte at absolute position gpos of the padded tail (or a plain block)
  always_comb begin
    gpos = blk2_r ? (rd_pos_r | 7'd64) : rd_pos_r;
    if (!pad_r || gpos < {1'b0, rem_r}) begin
      pbyte = br_data;
    end else if (gpos == {1'b0, rem_r}) begin
      pbyte = PAD_BYTE;
    end else if (gpos >= (two_r ? 7'd120 : 7'd56) && gpos[5:3] == 3'd7) begin
      pbyte = len_r[8'(7 - gpos[2:0]) * 8 +: 8];
    end else begin
      pbyte = 8'h00;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    two_nxt       = two_r;
    blk2_nxt      = blk2_r;
    pad_nxt       = pad_r;
    rem_nxt       = rem_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r && out_stall;
    rd_pend_nxt   = 1'b0;
    word_nxt      = word_r;
    word_valid    = 1'b0;
    cmd           = '0;
    if (rd_pend_r) begin
      word_nxt = {word_r[23:0], pbyte};
      word_valid = (rd_pos_r[1:0] == 2'd3);
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.byte_present) begin
            fill_nxt = fill_r + 6'd1;
            len_nxt  = len_r + 64'd8;
          end
          pos_nxt  = '0;
          blk2_nxt = 1'b0;
          if (in_data.byte_present && fill_r == 6'd63) begin
            pad_nxt   = 1'b0;
            two_nxt   = in_data.last_byte;
            rem_nxt   = '0;
            state_nxt = ST_LOAD;
          end else if (in_data.last_byte) begin
            pad_nxt   = 1'b1;
            rem_nxt   = in_data.byte_present ? fill_r + 6'd1 : fill_r;
            two_nxt   = (in_data.byte_present ? fill_r + 6'd1 : fill_r) >= 6'd56;
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        // start the engine, then stream 64 bytes; engine consumes words as they come
        cmd.start     = 1'b1;
        cmd.init_hash = first_r;
        first_nxt     = 1'b0;
        state_nxt     = ST_ROUND;
      end
      ST_ROUND: begin
        if (pos_r < 7'd64) begin
          // read the next byte of the block; the engine takes each word as it is completed
          rd_pend_nxt = 1'b1;
          pos_nxt     = pos_r + 7'd1;
        end
        if (!eng_busy && !rd_pend_r && pos_r == 7'd64) begin
          state_nxt = ST_FINAL;
        end
      end
      ST_FINAL: begin
        fill_nxt = '0;
        if (pad_r && two_r && !blk2_r) begin
          blk2_nxt  = 1'b1;
          pos_nxt   = '0;
          state_nxt = ST_LOAD;
        end else if (pad_r) begin
          state_nxt = ST_OUT;
        end else if (two_r) begin
          // full block closed by a last word: a padding-only block follows
          pad_nxt   = 1'b1;
          two_nxt   = 1'b0;
          rem_nxt   = '0;
          pos_nxt   = '0;
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PAD: begin
        state_nxt = ST_LOAD;
      end
      ST_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt = 1'b1;
          len_nxt       = '0;
          fill_nxt      = '0;
          first_nxt     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      two_r       <= 1'b0;
      blk2_r      <= 1'b0;
      pad_r       <= 1'b0;
      rem_r       <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      rd_pos_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      two_r       <= two_nxt;
      blk2_r      <= blk2_nxt;
      pad_r       <= pad_nxt;
      rem_r       <= rem_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      rd_pend_r   <= rd_pend_nxt;
      rd_pos_r    <= pos_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (state_r == ST_OUT && !out_valid_r) begin
      out_r <= hash;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("digest dropped");
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    eng_busy |-> in_stall) else $error("input taken while engine busy");
  a_fill_write: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_data.byte_present && !in_data.last_byte && fill_r != 6'd63)
      |=> fill_r == $past(fill_r) + 6'd1) else $error("fill count slip");
`endif
endmodule

// ----- sv/sha256_buf.sv -----
// sha256_buf: 64-byte block buffer memory, one byte written or read per cycle
// depends on nothing but the clock
`timescale 1ns / 1ps
module sha256_buf (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [5:0] wr_addr,
  input  logic [7:0] wr_data,
  input  logic [5:0] rd_addr,
  output logic [7:0] rd_data
);
  logic [7:0] mem [64];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ----- sv/sha256_eng.sv -----
// sha256_eng: compression engine, 16-word schedule memory; one round per cycle while
// its message word is ready. Depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_eng (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256_pkg::sha_cmd_t cmd,
  input  logic                 word_valid,
  input  logic [31:0]          word_in,
  output logic                 busy,
  output logic [255:0]         hash
);
  import sha256_pkg::*;

  logic [31:0]  sched [16];
  logic [31:0]  a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  logic [255:0] hash_r;
  logic [6:0]   rnd_r;
  logic         run_r;
  logic         wv_pend_r;
  logic [31:0]  w_r;
  logic [31:0]  w2, w7, w15, w16, s0, s1, wv, t1, t2;
  logic [5:0]   rix;

  // w2 and w7 come from a register view of the rolling schedule
  assign rix = rnd_r[5:0];
  assign w2  = sched[4'(rix - 6'd2)];
  assign w7  = sched[4'(rix - 6'd7)];
  assign w15 = sched[4'(rix - 6'd15)];
  assign w16 = sched[rix[3:0]];
  assign s1  = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
  assign s0  = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
  assign wv  = (rix < 6'd16) ? w_r : (s1 + w7 + s0 + w16);
  assign t1  = h_r + (rotr(e_r, 6) ^ rotr(e_r, 11) ^ rotr(e_r, 25)) +
               ((e_r & f_r) ^ (~e_r & g_r)) + ROUND_K[rix] + wv;
  assign t2  = (rotr(a_r, 2) ^ rotr(a_r, 13) ^ rotr(a_r, 22)) +
               ((a_r & b_r) ^ (a_r & c_r) ^ (b_r & c_r));

  // a round advances when its message word is ready (fed words first 16 rounds)
  logic step;
  assign step = run_r && (rix >= 6'd16 || wv_pend_r);
  assign busy = run_r;
  assign hash = hash_r;

  always_ff @(posedge clk) begin
    if (word_valid) begin
      w_r <= word_in;
    end
    if (step) begin
      sched[rix[3:0]] <= wv;
      h_r <= g_r; g_r <= f_r; f_r <= e_r; e_r <= d_r + t1;
      d_r <= c_r; c_r <= b_r; b_r <= a_r; a_r <= t1 + t2;
    end else if (cmd.start) begin
      {a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r} <= cmd.init_hash ? SHA_IV : hash_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r     <= 1'b0;
      rnd_r     <= '0;
      wv_pend_r <= 1'b0;
      hash_r    <= SHA_IV;
    end else begin
      wv_pend_r <= word_valid;
      if (cmd.start) begin
        run_r <= 1'b1;
        rnd_r <= '0;
        if (cmd.init_hash) begin
          hash_r <= SHA_IV;
        end
      end else if (step) begin
        rnd_r <= rnd_r + 7'd1;
        if (rnd_r == 7'd63) begin
          run_r  <= 1'b0;
          hash_r <= {hash_r[255:224] + (t1 + t2), hash_r[223:192] + a_r,
                     hash_r[191:160] + b_r, hash_r[159:128] + c_r,
                     hash_r[127:96] + d_r + t1, hash_r[95:64] + e_r,
                     hash_r[63:32] + f_r, hash_r[31:0] + g_r};
        end
      end else if (cmd.init_hash) begin
        hash_r <= SHA_IV;
      end
    end
  end

`ifndef SYNTH
  a_round_limit: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> rnd_r < 7'd64) else $error("round counter past 63");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !(step && rnd_r == 7'd63)) |-> !cmd.start) else $error("start while busy");
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && rnd_r == 7'd63) |=> !run_r) else $error("engine did not stop");
`endif
endmodule
